// ===== hdl/encp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encp_pkg: shared types and codes for the encoder edge counter
// Event op codes, field widths and the item/result structs used between
// the input stage and the update core.
// ----------------------------------------------------------------------------
package encp_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned WGT_W  = 9;

  localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
  localparam logic [OP_W-1:0] OP_RISE  = 3'd1;
  localparam logic [OP_W-1:0] OP_FALL  = 3'd2;
  localparam logic [OP_W-1:0] OP_TAKE  = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;
  localparam logic [OP_W-1:0] OP_ACK   = 3'd5;

  // full weight: old period kept, new interval ignored
  localparam logic [WGT_W-1:0] WGT_FULL  = 9'd256;
  localparam logic [WGT_W-1:0] WGT_RESET = 9'd77;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] now_us;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] delta_ticks;
    logic [WORD_W-1:0] total_ticks;
    logic [WORD_W-1:0] rise_count;
    logic [WORD_W-1:0] fall_count;
    logic [WORD_W-1:0] period_us;
    logic              fresh;
  } result_t;

endpackage

// ===== hdl/encp_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encp_in_stage: input register
// Captures one event per transfer and holds it until the core advances it.
// ----------------------------------------------------------------------------
module encp_in_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [encp_pkg::OP_W-1:0]     in_op,
  input  logic [encp_pkg::WORD_W-1:0]   in_now_us,
  input  logic                          adv,
  output logic                          s1_valid,
  output encp_pkg::item_t               s1_item
);

  logic            s1_valid_r;
  logic            s1_valid_nxt;
  encp_pkg::item_t s1_item_r;

  // stall only while a held item cannot move on
  assign in_stall = s1_valid_r && !adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r.op     <= in_op;
      s1_item_r.now_us <= in_now_us;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

// ===== hdl/encp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encp_core: counter state, period smoothing and result register
// Applies one event per cycle to the counters while the result is not stalled, and loads the result register.
// ----------------------------------------------------------------------------
module encp_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [encp_pkg::WGT_W-1:0]   cfg_wr_data,
  input  logic                         s1_valid,
  input  encp_pkg::item_t              s1_item,
  output logic                         adv,
  output logic                         out_valid,
  input  logic                         out_stall,
  output encp_pkg::result_t            res
);

  logic [encp_pkg::WGT_W-1:0]  mix_weight_r;
  logic [encp_pkg::WORD_W-1:0] tick_total_r, tick_total_nxt;
  logic [encp_pkg::WORD_W-1:0] taken_base_r, taken_base_nxt;
  logic [encp_pkg::WORD_W-1:0] rises_r, rises_nxt;
  logic [encp_pkg::WORD_W-1:0] falls_r, falls_nxt;
  logic [encp_pkg::WORD_W-1:0] period_r, period_nxt;
  logic [encp_pkg::WORD_W-1:0] last_rise_r, last_rise_nxt;
  logic                        fresh_r, fresh_nxt;
  logic                        out_valid_r, out_valid_nxt;
  encp_pkg::result_t           res_r, res_nxt;

  logic [encp_pkg::WGT_W-1:0]  wgt;
  logic [encp_pkg::WORD_W-1:0] interval;
  logic signed [32:0]          diff;
  logic signed [42:0]          prod;
  logic signed [42:0]          acc;
  logic [encp_pkg::WORD_W-1:0] smoothed;

  assign adv = s1_valid && (!out_valid_r || !out_stall);

  // w*old + (256-w)*iv == iv*256 + w*(old-iv): one multiplier
  assign wgt      = (mix_weight_r > encp_pkg::WGT_FULL) ? encp_pkg::WGT_FULL : mix_weight_r;
  assign interval = s1_item.now_us - last_rise_r;
  assign diff     = $signed({1'b0, period_r}) - $signed({1'b0, interval});
  assign prod     = $signed({1'b0, wgt}) * diff;
  assign acc      = $signed({3'b000, interval, 8'h00}) + prod;
  assign smoothed = acc[39:8];

  always_comb begin
    tick_total_nxt = tick_total_r;
    taken_base_nxt = taken_base_r;
    rises_nxt      = rises_r;
    falls_nxt      = falls_r;
    period_nxt     = period_r;
    last_rise_nxt  = last_rise_r;
    fresh_nxt      = fresh_r;
    case (s1_item.op)
      encp_pkg::OP_RISE: begin
        rises_nxt      = rises_r + 32'd1;
        tick_total_nxt = tick_total_r + 32'd1;
        fresh_nxt      = 1'b1;
        period_nxt     = smoothed;
        last_rise_nxt  = s1_item.now_us;
      end
      encp_pkg::OP_FALL: begin
        falls_nxt      = falls_r + 32'd1;
        tick_total_nxt = tick_total_r + 32'd1;
        fresh_nxt      = 1'b1;
      end
      encp_pkg::OP_TAKE: begin
        taken_base_nxt = tick_total_r;
        fresh_nxt      = 1'b0;
      end
      encp_pkg::OP_CLEAR: begin
        tick_total_nxt = '0;
        taken_base_nxt = '0;
      end
      encp_pkg::OP_ACK: begin
        fresh_nxt = 1'b0;
      end
      default: begin
      end
    endcase

    res_nxt.delta_ticks = tick_total_r - taken_base_r;
    res_nxt.total_ticks = tick_total_nxt;
    res_nxt.rise_count  = rises_nxt;
    res_nxt.fall_count  = falls_nxt;
    res_nxt.period_us   = period_nxt;
    res_nxt.fresh       = fresh_nxt;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_weight_r <= encp_pkg::WGT_RESET;
      tick_total_r <= '0;
      taken_base_r <= '0;
      rises_r      <= '0;
      falls_r      <= '0;
      period_r     <= '0;
      last_rise_r  <= '0;
      fresh_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mix_weight_r <= cfg_wr_data;
      end
      if (adv) begin
        tick_total_r <= tick_total_nxt;
        taken_base_r <= taken_base_nxt;
        rises_r      <= rises_nxt;
        falls_r      <= falls_nxt;
        period_r     <= period_nxt;
        last_rise_r  <= last_rise_nxt;
        fresh_r      <= fresh_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the result while stalled
  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_item.op == encp_pkg::OP_CLEAR |=> tick_total_r == '0 && taken_base_r == '0)
    else $error("clear did not zero total and base");

  a_take_moves_base: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_item.op == encp_pkg::OP_TAKE |=> !fresh_r && taken_base_r == tick_total_r)
    else $error("take did not move base or drop fresh");

  a_rise_counts: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_item.op == encp_pkg::OP_RISE |=>
      rises_r == $past(rises_r) + 32'd1 && fresh_r && out_valid_r)
    else $error("rising edge not counted");

  a_result_matches: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> res_r.total_ticks == tick_total_r && res_r.period_us == period_r)
    else $error("result register out of step with state");

endmodule

// ===== hdl/encoder_edge_counter_with_period_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_edge_counter_with_period_core: wheel encoder tick counter
// Counts encoder edges and keeps a smoothed rising-edge period.
//
// Input channel (in_valid / in_stall): one event per transfer, op code plus a
// microsecond timestamp. Ops: none, rising edge, falling edge, take delta,
// clear counts, acknowledge.
// Result channel (out_valid / out_stall): exactly one result per event: ticks
// since the last take (as before the event), then the totals, rise and fall
// counts, smoothed period and fresh flag as after the event.
// Config: cfg_wr_en writes cfg_wr_data into the 9-bit period mix weight
// (old-period weight in 1/256 units, values above 256 act as 256).
// Path: input register, then state update and result register to out_valid.
// Throughput: one event per cycle while results are not stalled, set by the
// state update with one 10x33 multiplier in the period mix.
// Reset (rst_n low, synchronous): all counters, period and timestamps clear,
// weight returns to 77, both channels empty.
// Stall: a stalled result holds; the input register keeps taking events until
// it is full, then in_stall rises in the same cycle.
// ----------------------------------------------------------------------------
module encoder_edge_counter_with_period_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [encp_pkg::WGT_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [encp_pkg::OP_W-1:0]     in_op,
  input  logic [encp_pkg::WORD_W-1:0]   in_now_us,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [encp_pkg::WORD_W-1:0]   out_delta_ticks,
  output logic [encp_pkg::WORD_W-1:0]   out_total_ticks,
  output logic [encp_pkg::WORD_W-1:0]   out_rise_count,
  output logic [encp_pkg::WORD_W-1:0]   out_fall_count,
  output logic [encp_pkg::WORD_W-1:0]   out_period_us,
  output logic                          out_fresh
);

  logic              s1_valid;
  logic              adv;
  encp_pkg::item_t   s1_item;
  encp_pkg::result_t res;

  encp_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_op     (in_op),
    .in_now_us (in_now_us),
    .adv       (adv),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item)
  );

  encp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s1_valid    (s1_valid),
    .s1_item     (s1_item),
    .adv         (adv),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .res         (res)
  );

  assign out_delta_ticks = res.delta_ticks;
  assign out_total_ticks = res.total_ticks;
  assign out_rise_count  = res.rise_count;
  assign out_fall_count  = res.fall_count;
  assign out_period_us   = res.period_us;
  assign out_fresh       = res.fresh;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for encoder_edge_counter_with_period_core
// Drives encoder events (edges, take, clear, acknowledge, unused codes) with
// random gaps and output back-pressure. Each transfer runs through a local
// predictor of the counters and the smoothed period, and every result is
// compared field by field with the oldest pending snapshot. The mix weight
// is swept across its range, including values above full weight.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [encp_pkg::OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [encp_pkg::OP_W-1:0] OP_SPARE_B = 3'd7;
  localparam int PIPE_LAT    = 2;
  localparam int HOLD_CYCLES = 250;
  localparam int PHASE_ITEMS = 500;
  localparam int LIMIT_NS    = 25_000_000;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_wr_en = 1'b0;
  logic [encp_pkg::WGT_W-1:0]    cfg_wr_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [encp_pkg::OP_W-1:0]     in_op = encp_pkg::OP_NONE;
  logic [encp_pkg::WORD_W-1:0]   in_now_us = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [encp_pkg::WORD_W-1:0]   out_delta_ticks;
  logic [encp_pkg::WORD_W-1:0]   out_total_ticks;
  logic [encp_pkg::WORD_W-1:0]   out_rise_count;
  logic [encp_pkg::WORD_W-1:0]   out_fall_count;
  logic [encp_pkg::WORD_W-1:0]   out_period_us;
  logic                          out_fresh;

  // predictor state
  logic [encp_pkg::WGT_W-1:0]  mix_wgt;
  logic [encp_pkg::WORD_W-1:0] edge_total;
  logic [encp_pkg::WORD_W-1:0] take_base;
  logic [encp_pkg::WORD_W-1:0] rise_total;
  logic [encp_pkg::WORD_W-1:0] fall_total;
  logic [encp_pkg::WORD_W-1:0] period_est;
  logic [encp_pkg::WORD_W-1:0] last_rise_us;
  logic                        edge_seen;

  encp_pkg::result_t           snapshot_q[$];
  int                          mismatch_cnt = 0;
  bit                          quiet = 1'b0;
  bit                          hold_req = 1'b0;
  logic [encp_pkg::WORD_W-1:0] wheel_us;

  encoder_edge_counter_with_period_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_now_us       (in_now_us),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_delta_ticks (out_delta_ticks),
    .out_total_ticks (out_total_ticks),
    .out_rise_count  (out_rise_count),
    .out_fall_count  (out_fall_count),
    .out_period_us   (out_period_us),
    .out_fresh       (out_fresh)
  );

  always #5 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic reset_counters();
    mix_wgt      = encp_pkg::WGT_RESET;
    edge_total   = '0;
    take_base    = '0;
    rise_total   = '0;
    fall_total   = '0;
    period_est   = '0;
    last_rise_us = '0;
    edge_seen    = 1'b0;
  endtask

  task automatic apply_event(input logic [encp_pkg::OP_W-1:0] op,
                             input logic [encp_pkg::WORD_W-1:0] now,
                             output encp_pkg::result_t snap);
    logic [encp_pkg::WGT_W-1:0]  w;
    logic [encp_pkg::WORD_W-1:0] gap_us;
    logic [40:0]                 acc;
    snap.delta_ticks = edge_total - take_base;
    case (op)
      encp_pkg::OP_RISE: begin
        w = (mix_wgt > encp_pkg::WGT_FULL) ? encp_pkg::WGT_FULL : mix_wgt;
        gap_us = now - last_rise_us;
        acc = 41'(w) * 41'(period_est) + (41'(encp_pkg::WGT_FULL) - 41'(w)) * 41'(gap_us);
        period_est   = acc[39:8];
        last_rise_us = now;
        rise_total   = rise_total + 1;
        edge_total   = edge_total + 1;
        edge_seen    = 1'b1;
      end
      encp_pkg::OP_FALL: begin
        fall_total = fall_total + 1;
        edge_total = edge_total + 1;
        edge_seen  = 1'b1;
      end
      encp_pkg::OP_TAKE: begin
        take_base = edge_total;
        edge_seen = 1'b0;
      end
      encp_pkg::OP_CLEAR: begin
        edge_total = '0;
        take_base  = '0;
      end
      encp_pkg::OP_ACK: edge_seen = 1'b0;
      default: ;
    endcase
    snap.total_ticks = edge_total;
    snap.rise_count  = rise_total;
    snap.fall_count  = fall_total;
    snap.period_us   = period_est;
    snap.fresh       = edge_seen;
  endtask

  task automatic send_event(input logic [encp_pkg::OP_W-1:0] op,
                            input logic [encp_pkg::WORD_W-1:0] now);
    int                gap;
    encp_pkg::result_t snap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_op     <= op;
    in_now_us <= now;
    do @(posedge clk); while (in_stall);
    apply_event(op, now, snap);
    snapshot_q.push_back(snap);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (snapshot_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  // call only when idle
  task automatic write_weight(input logic [encp_pkg::WGT_W-1:0] w);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mix_wgt = w;
  endtask

  // mostly a turning wheel with rising timestamps; some raw noise
  task automatic next_random_event(output logic [encp_pkg::OP_W-1:0] op,
                                   output logic [encp_pkg::WORD_W-1:0] now);
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      op  = encp_pkg::OP_W'($urandom_range(0, 7));
      now = $urandom;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 90) wheel_us = wheel_us + $urandom_range(1, 4000);
      else if (r < 98) wheel_us = wheel_us + $urandom_range(4000, 2_000_000);
      else wheel_us = wheel_us + $urandom;
      now = wheel_us;
      r = $urandom_range(0, 99);
      if (r < 42) op = encp_pkg::OP_RISE;
      else if (r < 84) op = encp_pkg::OP_FALL;
      else if (r < 92) op = encp_pkg::OP_TAKE;
      else if (r < 96) op = encp_pkg::OP_ACK;
      else if (r < 98) op = encp_pkg::OP_CLEAR;
      else op = encp_pkg::OP_NONE;
    end
  endtask

  task automatic test_directed_edges();
    encp_pkg::item_t seq[20];
    seq = '{
      '{encp_pkg::OP_NONE,  32'd0},         '{encp_pkg::OP_RISE,  32'd1000},
      '{encp_pkg::OP_FALL,  32'd1500},      '{encp_pkg::OP_RISE,  32'd2000},
      '{encp_pkg::OP_TAKE,  32'd2100},      '{encp_pkg::OP_TAKE,  32'd2200},
      '{encp_pkg::OP_FALL,  32'd2300},      '{encp_pkg::OP_ACK,   32'd2400},
      '{encp_pkg::OP_RISE,  32'hFFFF_FFF0}, '{encp_pkg::OP_RISE,  32'h0000_0010},
      '{encp_pkg::OP_CLEAR, 32'h0000_0020}, '{encp_pkg::OP_TAKE,  32'h0000_0030},
      '{OP_SPARE_A,         32'hFFFF_FFFF}, '{OP_SPARE_B,         32'hAAAA_5555},
      '{encp_pkg::OP_FALL,  32'h0000_0040}, '{encp_pkg::OP_RISE,  32'hFFFF_FFFF},
      '{encp_pkg::OP_RISE,  32'hFFFF_FFFF}, '{encp_pkg::OP_CLEAR, 32'h5555_AAAA},
      '{encp_pkg::OP_ACK,   32'h0000_0000}, '{encp_pkg::OP_RISE,  32'h1234_5678}
    };
    foreach (seq[i]) send_event(seq[i].op, seq[i].now_us);
    wait_idle();
  endtask

  // zero, full, above full (held period), and values in between
  task automatic test_weight_extremes();
    logic [encp_pkg::WGT_W-1:0]  wgts[7];
    logic [encp_pkg::OP_W-1:0]   op;
    logic [encp_pkg::WORD_W-1:0] now;
    wgts = '{9'd0, encp_pkg::WGT_FULL, 9'd511, 9'd257, 9'd1, 9'd255, 9'd128};
    foreach (wgts[i]) begin
      write_weight(wgts[i]);
      repeat (12) begin
        next_random_event(op, now);
        send_event(op, now);
      end
      send_event(encp_pkg::OP_RISE, $urandom);
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    logic [encp_pkg::OP_W-1:0]   op;
    logic [encp_pkg::WORD_W-1:0] now;
    write_weight(encp_pkg::WGT_RESET);
    quiet    = 1'b1;
    hold_req = 1'b1;
    repeat (40) begin
      next_random_event(op, now);
      send_event(op, now);
    end
    quiet = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_traffic();
    logic [encp_pkg::OP_W-1:0]   op;
    logic [encp_pkg::WORD_W-1:0] now;
    for (int ph = 0; ph < 4; ph++) begin
      write_weight(ph == 0 ? encp_pkg::WGT_RESET
                           : encp_pkg::WGT_W'($urandom_range(0, 511)));
      // start one phase just below the timestamp wrap
      if (ph == 1) wheel_us = 32'hFFFF_0000;
      quiet = (ph == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // one stretch without any idling in the middle of a phase
        if (ph == 3) quiet = (n >= 200 && n < 300);
        next_random_event(op, now);
        send_event(op, now);
      end
      quiet = 1'b0;
      wait_idle();
    end
  endtask

  task automatic check_word(input string fname, input logic [encp_pkg::WORD_W-1:0] exp_v,
                            input logic [encp_pkg::WORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, fname, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk) begin
    encp_pkg::result_t snap;
    if (rst_n && out_valid && !out_stall) begin
      if (snapshot_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, got total %h", $time,
                 out_total_ticks);
        mismatch_cnt++;
      end else begin
        snap = snapshot_q.pop_front();
        check_word("delta_ticks", snap.delta_ticks, out_delta_ticks);
        check_word("total_ticks", snap.total_ticks, out_total_ticks);
        check_word("rise_count",  snap.rise_count,  out_rise_count);
        check_word("fall_count",  snap.fall_count,  out_fall_count);
        check_word("period_us",   snap.period_us,   out_period_us);
        check_word("fresh",       encp_pkg::WORD_W'(snap.fresh),
                   encp_pkg::WORD_W'(out_fresh));
      end
    end
  end

  // result side: random stalls, or one long hold-off on request
  initial begin
    int g;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        g = pick_gap();
        if (g == 0) begin
          out_stall <= 1'b0;
        end else begin
          out_stall <= 1'b1;
          repeat (g) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("FAIL");
    $finish;
  end

  initial begin
    reset_counters();
    wheel_us = $urandom;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_weight_extremes();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== encoder_edge_counter_with_period_core.f =====
hdl/encp_pkg.sv
hdl/encp_in_stage.sv
hdl/encp_core.sv
hdl/encoder_edge_counter_with_period_core.sv
dv/tb.sv
